FILE: sv/vcos_pkg.sv
// Shared types and constants for the voxel chunk occupancy store.
// Holds operation codes, register indexes, field widths and the
// command/status structs between controller and datapath.
package vcos_pkg;

  localparam int FUNC_W    = 3;
  localparam int POS_W     = 32;
  localparam int OCC_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 104;
  localparam int M_DATA_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_INFL   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_INFL = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_READ_INFL  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

  localparam logic [OCC_W-1:0] OCC_MAX = 2'd3;
  localparam logic [OCC_W-1:0] OCC_INC = 2'd2;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/vcos_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vcos_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/vcos_ctrl.sv
// Controller for the voxel chunk occupancy store: clearing pass, accept,
// read and write-back sequencing. Depends on vcos_pkg.
module vcos_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  vcos_pkg::sts_t sts,
  output vcos_pkg::cmd_t cmd
);
  import vcos_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;
  localparam logic [1:0] ST_DATA  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.rd     = 1'b1;
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (sts.out_free) begin
          cmd.wb     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/vcos_dp.sv
// Datapath for the voxel chunk occupancy store: origin registers, range
// check, cell index, cell RAM, counter update and output register.
// Depends on vcos_pkg and vcos_ram.
module vcos_dp #(
  parameter int CHUNK_SIDE = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vcos_pkg::cmd_t                      cmd,
  output vcos_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [vcos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcos_pkg::POS_W-1:0]          cfg_data,
  input  logic [vcos_pkg::S_DATA_W-1:0]       s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [vcos_pkg::M_DATA_W-1:0]       m_tdata
);
  import vcos_pkg::*;

  localparam int CELLS  = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int REL_W  = $clog2(CHUNK_SIDE);
  localparam logic [CELL_W-1:0] SIDE      = CELL_W'(CHUNK_SIDE);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
  localparam logic [POS_W:0]    SIDE_EXT  = (POS_W+1)'(CHUNK_SIDE);

  logic [POS_W-1:0]  org_x, org_y, org_z;
  logic [FUNC_W-1:0] func_q;
  logic [REL_W-1:0]  rel_x, rel_y, rel_z;
  logic              oob;
  logic [CELL_W-1:0] cell_addr;
  logic [CELL_W-1:0] clr_addr;
  logic [CELL_W-1:0] idx;

  logic [FUNC_W-1:0] in_func;
  logic [POS_W-1:0]  in_x, in_y, in_z;
  logic [POS_W:0]    dx, dy, dz;
  logic              in_ok;

  logic [OCC_W:0]    rdata;
  logic [OCC_W-1:0]  occ_new;
  logic              infl_new;
  logic              ram_we;
  logic [CELL_W-1:0] ram_waddr;
  logic [OCC_W:0]    ram_wdata;

  assign in_func = s_tdata[FUNC_W-1:0];
  assign in_x    = s_tdata[FUNC_W +: POS_W];
  assign in_y    = s_tdata[FUNC_W+POS_W +: POS_W];
  assign in_z    = s_tdata[FUNC_W+2*POS_W +: POS_W];

  assign dx = {in_x[POS_W-1], in_x} - {org_x[POS_W-1], org_x};
  assign dy = {in_y[POS_W-1], in_y} - {org_y[POS_W-1], org_y};
  assign dz = {in_z[POS_W-1], in_z} - {org_z[POS_W-1], org_z};

  assign in_ok = !dx[POS_W] && (dx < SIDE_EXT) &&
                 !dy[POS_W] && (dy < SIDE_EXT) &&
                 !dz[POS_W] && (dz < SIDE_EXT);

  assign idx = (CELL_W'(rel_z) * SIDE + CELL_W'(rel_y)) * SIDE + CELL_W'(rel_x);

  assign sts.clr_last = (clr_addr == LAST_CELL);
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x <= cfg_data;
        REG_ORIGIN_Y: org_y <= cfg_data;
        REG_ORIGIN_Z: org_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      oob    <= !in_ok;
      rel_x  <= dx[REL_W-1:0];
      rel_y  <= dy[REL_W-1:0];
      rel_z  <= dz[REL_W-1:0];
    end
    if (cmd.rd) begin
      cell_addr <= oob ? '0 : idx;
    end
  end

  always_comb begin
    occ_new  = rdata[OCC_W-1:0];
    infl_new = rdata[OCC_W];
    case (func_q)
      FUNC_INSERT: begin
        occ_new = (rdata[OCC_W-1:0] == '0) ? OCC_INC : OCC_MAX;
      end
      FUNC_DELETE: begin
        if (rdata[OCC_W-1:0] != '0) begin
          occ_new = rdata[OCC_W-1:0] - 1'b1;
        end
      end
      FUNC_SET_INFL:   infl_new = 1'b1;
      FUNC_CLEAR_INFL: infl_new = 1'b0;
      default: ;
    endcase
  end

  assign ram_we    = cmd.clr || (cmd.wb && !oob);
  assign ram_waddr = cmd.clr ? clr_addr : cell_addr;
  assign ram_wdata = cmd.clr ? '0 : {infl_new, occ_new};

  vcos_ram #(
    .WIDTH (OCC_W + 1),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (oob ? '0 : idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.wb) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      m_tdata <= {(M_DATA_W-OCC_W-2)'(0), oob, infl_new && !oob,
                  oob ? {OCC_W{1'b0}} : occ_new};
    end
  end

endmodule

FILE: sv/voxel_chunk_occupancy_store.sv
// Voxel chunk occupancy store: a CHUNK_SIDE^3 cube of 2-bit saturating
// occupancy counters and 1-bit inflation flags, anchored at a world origin.
// Each word passes through accept, RAM read and write-back into the output
// register, the single read-modify-write of the cell RAM; a result not yet
// taken holds the write-back, and no new word is accepted until it is done.
// After reset a clearing pass writes every one of the CHUNK_SIDE^3 cells
// (4096 at the default) with s_tready low; origin writes are taken throughout.
// A coordinate outside the chunk reports out_of_chunk with zero fields and
// changes nothing. Depends on vcos_pkg, vcos_ctrl, vcos_dp and vcos_ram.
module voxel_chunk_occupancy_store #(
  parameter int CHUNK_SIDE = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vcos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vcos_pkg::POS_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // func[2:0], pos_x[34:3], pos_y[66:35], pos_z[98:67], zero[103:99]
  input  logic [vcos_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // occupancy[1:0], inflated[2], out_of_chunk[3], zero[7:4]
  output logic [vcos_pkg::M_DATA_W-1:0]  m_tdata
);
  import vcos_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vcos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vcos_dp #(
    .CHUNK_SIDE (CHUNK_SIDE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: verif/voxel_chunk_occupancy_store_tb.sv
// Testbench for voxel_chunk_occupancy_store: directed table, then random phases with idling.
// Each word is checked in order against the table or a voxel predictor. Depends on vcos_pkg.
`timescale 1ns / 1ps

module voxel_chunk_occupancy_store_tb;
  import vcos_pkg::*;

  localparam int SIDE = 16;
  localparam int CELLS = SIDE * SIDE * SIDE;
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic             ooc;
    logic             infl;
    logic [OCC_W-1:0] occ;
  } cell_result_t;

  typedef enum logic {ROW_WORD, ROW_ORIGIN} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [FUNC_W-1:0] op;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    bit                typed;
    cell_result_t      want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [POS_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;

  logic [OCC_W-1:0]      occ_cells [CELLS];
  logic                  infl_cells [CELLS];
  logic [POS_W-1:0]      org_x = '0;
  logic [POS_W-1:0]      org_y = '0;
  logic [POS_W-1:0]      org_z = '0;

  cell_result_t          pending_results [$];
  dir_row_t              dir_rows [$];
  int                    errors = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_left = 0;
  cell_result_t          seen;
  cell_result_t          want;

  voxel_chunk_occupancy_store DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic cell_result_t apply_voxel_op(logic [FUNC_W-1:0] op, logic [POS_W-1:0] px,
                                                  logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
    longint dx;
    longint dy;
    longint dz;
    int cell_idx;
    cell_result_t r;
    dx = longint'($signed(px)) - longint'($signed(org_x));
    dy = longint'($signed(py)) - longint'($signed(org_y));
    dz = longint'($signed(pz)) - longint'($signed(org_z));
    r = '0;
    if (dx < 0 || dx >= SIDE || dy < 0 || dy >= SIDE || dz < 0 || dz >= SIDE) begin
      r.ooc = 1'b1;
      return r;
    end
    cell_idx = int'(dz) * SIDE * SIDE + int'(dy) * SIDE + int'(dx);
    case (op)
      FUNC_INSERT: begin
        occ_cells[cell_idx] = (occ_cells[cell_idx] >= OCC_MAX - OCC_INC) ? OCC_MAX
                                                                          : occ_cells[cell_idx] + OCC_INC;
      end
      FUNC_DELETE: begin
        if (occ_cells[cell_idx] != 0) occ_cells[cell_idx] = occ_cells[cell_idx] - 1'b1;
      end
      FUNC_SET_INFL:   infl_cells[cell_idx] = 1'b1;
      FUNC_CLEAR_INFL: infl_cells[cell_idx] = 1'b0;
      default: ;
    endcase
    r.occ = occ_cells[cell_idx];
    r.infl = infl_cells[cell_idx];
    return r;
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
                           input bit typed, input cell_result_t typed_want);
    cell_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - FUNC_W - 3 * POS_W){1'b0}}, pz, py, px, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_voxel_op(op, px, py, pz);
    pending_results.push_back(typed ? typed_want : r);
  endtask

  task automatic wait_drained(input int extra);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_origin(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                            input logic [POS_W-1:0] oz);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data <= oy;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Z;
    cfg_data <= oz;
    @(posedge clk);
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    org_z = oz;
  endtask

  function automatic void dir_word(logic [FUNC_W-1:0] op, logic [POS_W-1:0] x,
                                   logic [POS_W-1:0] y, logic [POS_W-1:0] z, bit typed,
                                   logic [OCC_W-1:0] occ, logic infl, logic ooc);
    dir_row_t row;
    row.kind = ROW_WORD;
    row.op = op;
    row.x = x;
    row.y = y;
    row.z = z;
    row.typed = typed;
    row.want = '{ooc: ooc, infl: infl, occ: occ};
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_origin(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                     logic [POS_W-1:0] z);
    dir_row_t row;
    row = '{kind: ROW_ORIGIN, op: FUNC_LOOKUP, x: x, y: y, z: z, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  task automatic random_word();
    logic [POS_W-1:0] org [3];
    logic [POS_W-1:0] p [3];
    logic [FUNC_W-1:0] op;
    int axis;
    org[0] = org_x;
    org[1] = org_y;
    org[2] = org_z;
    for (int a = 0; a < 3; a++) begin
      p[a] = org[a] + (($urandom_range(0, 99) < 60) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, SIDE - 1));
    end
    if ($urandom_range(0, 99) >= 80) begin
      axis = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: p[axis] = org[axis] + SIDE;
        1: p[axis] = org[axis] - 1;
        2: p[axis] = p[axis] + 32'h8000_0000;
        default: p[axis] = $urandom;
      endcase
    end
    if ($urandom_range(0, 19) == 0) op = ($urandom_range(0, 1) != 0) ? FUNC_SPARE7 : FUNC_SPARE6;
    else op = FUNC_W'($urandom_range(0, 5));
    send_word(op, p[0], p[1], p[2], 1'b0, '0);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                           input int hold, input int pause_at, input logic [POS_W-1:0] ox,
                           input logic [POS_W-1:0] oy, input logic [POS_W-1:0] oz);
    wait_drained(6);
    set_origin(ox, oy, oz);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold > 0) hold_left = hold;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_drained(0);
      random_word();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[3:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (seen.occ !== want.occ) begin
          errors++;
          $display("%0t: occupancy expected %0d, got %0d", $time, want.occ, seen.occ);
        end
        if (seen.infl !== want.infl) begin
          errors++;
          $display("%0t: inflated expected %0d, got %0d", $time, want.infl, seen.infl);
        end
        if (seen.ooc !== want.ooc) begin
          errors++;
          $display("%0t: out_of_chunk expected %0d, got %0d", $time, want.ooc, seen.ooc);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      occ_cells[i] = '0;
      infl_cells[i] = 1'b0;
    end
    dir_word(FUNC_LOOKUP, 0, 0, 0, 1, 2'd0, 0, 0);
    dir_word(FUNC_INSERT, 0, 0, 0, 1, 2'd2, 0, 0);
    dir_word(FUNC_INSERT, 0, 0, 0, 1, 2'd3, 0, 0);
    dir_word(FUNC_INSERT, 0, 0, 0, 1, 2'd3, 0, 0);
    dir_word(FUNC_DELETE, 0, 0, 0, 1, 2'd2, 0, 0);
    dir_word(FUNC_DELETE, 0, 0, 0, 1, 2'd1, 0, 0);
    dir_word(FUNC_DELETE, 0, 0, 0, 1, 2'd0, 0, 0);
    dir_word(FUNC_DELETE, 0, 0, 0, 1, 2'd0, 0, 0);
    dir_word(FUNC_SET_INFL, 15, 15, 15, 1, 2'd0, 1, 0);
    dir_word(FUNC_READ_INFL, 15, 15, 15, 1, 2'd0, 1, 0);
    dir_word(FUNC_INSERT, 15, 15, 15, 1, 2'd2, 1, 0);
    dir_word(FUNC_CLEAR_INFL, 15, 15, 15, 1, 2'd2, 0, 0);
    dir_word(FUNC_SPARE6, 15, 15, 15, 1, 2'd2, 0, 0);
    dir_word(FUNC_SPARE7, 15, 15, 15, 1, 2'd2, 0, 0);
    dir_word(FUNC_INSERT, 16, 0, 0, 1, 2'd0, 0, 1);
    dir_word(FUNC_INSERT, 32'hFFFF_FFFF, 0, 0, 1, 2'd0, 0, 1);
    dir_word(FUNC_SET_INFL, 0, 16, 0, 1, 2'd0, 0, 1);
    dir_word(FUNC_LOOKUP, 0, 0, 32'h8000_0000, 1, 2'd0, 0, 1);
    dir_word(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2'd0, 0, 1);
    dir_word(FUNC_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 2'd0, 0, 1);
    dir_word(FUNC_READ_INFL, 7, 3, 12, 0, 2'd0, 0, 0);
    dir_origin(32'h7FFF_FFF1, 32'h8000_0000, 32'h7FFF_FFF0);
    dir_word(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFF0, 1, 2'd0, 0, 1);
    dir_word(FUNC_INSERT, 32'h7FFF_FFF1, 32'h8000_0000, 32'h7FFF_FFF0, 1, 2'd2, 0, 0);
    dir_word(FUNC_INSERT, 32'h7FFF_FFFF, 32'h8000_000F, 32'h7FFF_FFFF, 0, 2'd0, 0, 0);
    dir_word(FUNC_LOOKUP, 32'h7FFF_FFF1, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 1, 2'd0, 0, 1);
    dir_word(FUNC_DELETE, 32'h7FFF_FFF2, 32'h8000_0001, 32'h7FFF_FFF0, 0, 2'd0, 0, 0);

    @(negedge rst);
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_ORIGIN) begin
        wait_drained(6);
        set_origin(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    run_phase(90, 0, 0, 0, -1, $urandom, $urandom, $urandom);
    run_phase(90, 77, 0, 0, -1, 32'h8000_0000, 32'h7FFF_FFF0, 32'h7FFF_FFFF);
    run_phase(90, 0, 77, 0, -1, $urandom, $urandom, $urandom);
    run_phase(90, 23, 23, 0, 45, 32'hFFFF_FFF8, $urandom, 32'h0000_0100);
    run_phase(90, 0, 0, 300, -1, $urandom, 32'h8000_0000, $urandom);
    run_phase(100, 0, 0, 0, -1, 0, 0, 0);

    wait_drained(12);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: files.f
sv/vcos_pkg.sv
sv/vcos_ram.sv
sv/vcos_ctrl.sv
sv/vcos_dp.sv
sv/voxel_chunk_occupancy_store.sv
verif/voxel_chunk_occupancy_store_tb.sv
